@@ rtl/tfj_pkg.sv @@
// Package for the text full-justify block: sizes, blank code and the
// command/status bundles between controller and datapath. No dependencies.
package tfj_pkg;

    localparam int MAX_WIDTH        = 64;
    localparam int BYTES_PER_RESULT = 8;
    localparam int LANE_W           = 3;
    localparam int POS_W            = 7;
    localparam int RING_DEPTH       = 128;
    localparam int RING_AW          = 7;
    localparam int MAX_WORDS        = 32;
    localparam int WIDX_W           = 5;
    localparam int CNT_W            = 6;
    localparam logic [7:0] BLANK    = 8'h20;
    localparam logic [POS_W-1:0] RESET_WIDTH = 7'd64;

    typedef struct packed {
        logic store;
        logic append;
        logic clear_line;
        logic clr_ovf;
        logic setup;
        logic load_word;
        logic letter;
        logic div_start;
        logic gap_load;
        logic gap;
        logic next_word;
        logic pad;
        logic justify;
        logic final_line;
    } tfj_cmd_t;

    typedef struct packed {
        logic flush;
        logic last_letter;
        logic more_words;
        logic gap_last;
        logic line_full;
        logic prod_ok;
        logic div_done;
        logic gaps_nz;
    } tfj_stat_t;

endpackage

@@ rtl/tfj_if.sv @@
// Valid/ready channel interfaces for input characters, output beats and
// the width register write. Depends on nothing.
interface tfj_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       word_end;
    logic       text_end;
    modport source (output valid, character, word_end, text_end, input ready);
    modport sink (input valid, character, word_end, text_end, output ready);
endinterface

interface tfj_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] packed_chars;
    logic [3:0]  char_count;
    logic        line_end;
    logic        word_too_long;
    logic        run_last;
    modport source (output valid, packed_chars, char_count, line_end, word_too_long, run_last,
                    input ready);
    modport sink (input valid, packed_chars, char_count, line_end, word_too_long, run_last,
                  output ready);
endinterface

interface tfj_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] line_width;
    modport source (output valid, line_width, input ready);
    modport sink (input valid, line_width, output ready);
endinterface

@@ rtl/text_full_justify.sv @@
// Top level of the greedy full-justify block: joins controller and datapath.
// Depends on tfj_pkg, tfj_if, tfj_ctrl, tfj_datapath.
//
//  channel | direction | payload
//  chars   | in        | character, word_end, text_end
//  lines   | out       | packed_chars, char_count, line_end, word_too_long, run_last
//  cfg     | in        | line_width (always ready)
//
// A character inside a word is taken in S_IDLE; a word end adds a decision state, S_DECIDE.
// A line emission walks S_SETUP, per word S_WORD and S_LET per letter (S_RD between
// letters, for the registered ring read), per gap S_GPREP, S_DIV (serial divider)
// if justified and S_GAP per blank, then S_PAD, S_END and S_APPEND if a word follows.
// Output beats wait in an output register; a stalled sink holds the line walk.
// Reset needs no clearing pass; chars is not ready while a line is emitted.
module text_full_justify (
    input logic       clk,
    input logic       rst_n,
    tfj_in_if.sink    chars,
    tfj_out_if.source lines,
    tfj_cfg_if.sink   cfg
);
    import tfj_pkg::*;

    tfj_cmd_t  cmd;
    tfj_stat_t stat;
    logic      cfg_write;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid;

    tfj_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chars.valid),
        .word_end (chars.word_end),
        .text_end (chars.text_end),
        .in_ready (chars.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tfj_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_write (cfg_write),
        .cfg_data  (cfg.line_width),
        .in_char   (chars.character),
        .lines     (lines)
    );

endmodule

@@ rtl/tfj_div.sv @@
// Restoring divider, one quotient bit per cycle, for the per-gap blank share.
// Depends on tfj_pkg.
module tfj_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [tfj_pkg::POS_W-1:0]  num,
    input  logic [tfj_pkg::WIDX_W-1:0] den,
    output logic                       done,
    output logic [tfj_pkg::POS_W-1:0]  quo
);
    import tfj_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [2:0]          cnt_reg, cnt_next;
    logic [WIDX_W-1:0]   rem_reg, rem_next;
    logic [POS_W-1:0]    quo_reg, quo_next;
    logic [WIDX_W:0]     trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        trial     = {rem_reg, quo_reg[POS_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 3'(POS_W);
            rem_next  = '0;
            quo_next  = num;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den})
            begin
                rem_next = WIDX_W'(trial - {1'b0, den});
                quo_next = {quo_reg[POS_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[WIDX_W-1:0];
                quo_next = {quo_reg[POS_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 3'd1;
            if (cnt_reg == 3'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

@@ rtl/tfj_datapath.sv @@
// Datapath: width register, word ring memory, word lengths, line walk
// counters, beat packing and output register. Depends on tfj_pkg, tfj_if, tfj_div.
module tfj_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  tfj_pkg::tfj_cmd_t   cmd,
    output tfj_pkg::tfj_stat_t  stat,
    input  logic                cfg_write,
    input  logic [6:0]          cfg_data,
    input  logic [7:0]          in_char,
    tfj_out_if.source           lines
);
    import tfj_pkg::*;

    logic [POS_W-1:0]  width_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [POS_W-1:0]  letters_reg;
    logic [POS_W-1:0]  pending_reg;
    logic              ovf_reg;
    logic [RING_AW-1:0] base_reg;
    logic [7:0]        ring [RING_DEPTH];
    logic [7:0]        rd_data_reg;
    logic [POS_W-1:0]  wlen [MAX_WORDS];
    logic [POS_W-1:0]  pos_reg;
    logic [RING_AW-1:0] src_reg;
    logic [WIDX_W-1:0] wi_reg;
    logic [POS_W-1:0]  lr_reg;
    logic [POS_W-1:0]  gr_reg;
    logic [POS_W-1:0]  blanks_reg;
    logic [WIDX_W-1:0] gaps_reg;
    logic [7:0]        pack_reg [BYTES_PER_RESULT];

    logic              out_valid_reg;
    logic [63:0]       out_data_reg;
    logic [3:0]        out_cnt_reg;
    logic              out_end_reg;
    logic              out_ovf_reg;
    logic              out_last_reg;

    logic [POS_W-1:0]   eff_width;
    logic [RING_AW-1:0] waddr;
    logic [7:0]         need;
    logic               prod;
    logic [7:0]         prod_char;
    logic [LANE_W-1:0]  lane;
    logic               at_end;
    logic               beat_cond;
    logic [63:0]        beat_data;
    logic               div_done;
    logic [POS_W-1:0]   div_q;
    logic [POS_W-1:0]   div_num;

    assign eff_width = (cfg_data == '0) ? 7'd1 :
                       (cfg_data > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : cfg_data;
    assign waddr     = base_reg + letters_reg + pending_reg;
    assign need      = {1'b0, letters_reg} + {2'b0, count_reg} + {1'b0, pending_reg};
    assign prod      = cmd.letter | cmd.gap | cmd.pad;
    assign prod_char = cmd.letter ? rd_data_reg : BLANK;
    assign lane      = pos_reg[LANE_W-1:0];
    assign at_end    = (pos_reg + 7'd1) == width_reg;
    assign beat_cond = (lane == LANE_W'(BYTES_PER_RESULT - 1)) || at_end;
    assign div_num   = blanks_reg + {2'b0, gaps_reg} - 7'd1;

    always_comb
    begin
        for (int j = 0; j < BYTES_PER_RESULT; j++)
        begin
            if (LANE_W'(j) < lane)
                beat_data[8*j +: 8] = pack_reg[j];
            else if (LANE_W'(j) == lane)
                beat_data[8*j +: 8] = prod_char;
            else
                beat_data[8*j +: 8] = 8'h00;
        end
    end

    assign stat.flush       = (count_reg != '0) && (need > {1'b0, width_reg});
    assign stat.last_letter = lr_reg == 7'd1;
    assign stat.more_words  = ({1'b0, wi_reg} + 6'd1) < count_reg;
    assign stat.gap_last    = gr_reg == 7'd1;
    assign stat.line_full   = pos_reg == width_reg;
    assign stat.prod_ok     = !beat_cond || !out_valid_reg || lines.ready;
    assign stat.div_done    = div_done;
    assign stat.gaps_nz     = gaps_reg != '0;

    tfj_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (gaps_reg),
        .done  (div_done),
        .quo   (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= RESET_WIDTH;
            count_reg   <= '0;
            letters_reg <= '0;
            pending_reg <= '0;
            ovf_reg     <= 1'b0;
            base_reg    <= '0;
        end
        else if (cfg_write)
        begin
            width_reg   <= eff_width;
            count_reg   <= '0;
            letters_reg <= '0;
            pending_reg <= '0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.store)
            begin
                if (pending_reg < width_reg)
                    pending_reg <= pending_reg + 7'd1;
                else
                    ovf_reg <= 1'b1;
            end
            if (cmd.append)
            begin
                letters_reg <= letters_reg + pending_reg;
                count_reg   <= count_reg + 6'd1;
                pending_reg <= '0;
            end
            if (cmd.clear_line)
            begin
                base_reg    <= base_reg + letters_reg;
                letters_reg <= '0;
                count_reg   <= '0;
            end
            if (cmd.clr_ovf)
                ovf_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store && pending_reg < width_reg)
            ring[waddr] <= in_char;
        rd_data_reg <= ring[src_reg];
        if (cmd.append)
            wlen[count_reg[WIDX_W-1:0]] <= pending_reg;
        if (cmd.setup)
        begin
            pos_reg    <= '0;
            src_reg    <= base_reg;
            wi_reg     <= '0;
            blanks_reg <= width_reg - letters_reg;
            gaps_reg   <= WIDX_W'(count_reg - 6'd1);
        end
        if (cmd.load_word)
            lr_reg <= wlen[wi_reg];
        if (prod)
        begin
            pack_reg[lane] <= prod_char;
            pos_reg        <= pos_reg + 7'd1;
        end
        if (cmd.letter)
        begin
            src_reg <= src_reg + 7'd1;
            lr_reg  <= lr_reg - 7'd1;
        end
        if (cmd.gap_load)
        begin
            if (cmd.justify && gaps_reg != '0)
            begin
                gr_reg     <= div_q;
                blanks_reg <= (blanks_reg >= div_q) ? blanks_reg - div_q : '0;
                gaps_reg   <= gaps_reg - 5'd1;
            end
            else
                gr_reg <= 7'd1;
        end
        if (cmd.gap)
            gr_reg <= gr_reg - 7'd1;
        if (cmd.next_word)
            wi_reg <= wi_reg + 5'd1;
        if (prod && beat_cond)
        begin
            out_data_reg <= beat_data;
            out_cnt_reg  <= {1'b0, lane} + 4'd1;
            out_end_reg  <= at_end;
            out_ovf_reg  <= ovf_reg;
            out_last_reg <= at_end && cmd.final_line;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (prod && beat_cond)
            out_valid_reg <= 1'b1;
        else if (lines.ready)
            out_valid_reg <= 1'b0;
    end

    assign lines.valid         = out_valid_reg;
    assign lines.packed_chars  = out_data_reg;
    assign lines.char_count    = out_cnt_reg;
    assign lines.line_end      = out_end_reg;
    assign lines.word_too_long = out_ovf_reg;
    assign lines.run_last      = out_last_reg;

    a_prod_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        prod |-> pos_reg < width_reg)
        else $error("byte produced past line width");
    a_word_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |-> count_reg < 6'(MAX_WORDS))
        else $error("word length table overrun");
    a_line_fits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.setup |-> letters_reg <= width_reg)
        else $error("held letters exceed width at line start");

endmodule

@@ rtl/tfj_ctrl.sv @@
// Controller state machine: input acceptance, fit decision and the walk
// over words, gaps and padding of one line. Depends on tfj_pkg.
module tfj_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                word_end,
    input  logic                text_end,
    output logic                in_ready,
    input  tfj_pkg::tfj_stat_t  stat,
    output tfj_pkg::tfj_cmd_t   cmd
);
    import tfj_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECIDE = 4'd1;
    localparam logic [3:0] S_SETUP  = 4'd2;
    localparam logic [3:0] S_WORD   = 4'd3;
    localparam logic [3:0] S_LET    = 4'd4;
    localparam logic [3:0] S_RD     = 4'd5;
    localparam logic [3:0] S_GPREP  = 4'd6;
    localparam logic [3:0] S_DIV    = 4'd7;
    localparam logic [3:0] S_GAP    = 4'd8;
    localparam logic [3:0] S_PAD    = 4'd9;
    localparam logic [3:0] S_END    = 4'd10;
    localparam logic [3:0] S_APPEND = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       te_reg, te_next;
    logic       just_reg, just_next;

    always_comb
    begin
        state_next = state_reg;
        te_next    = te_reg;
        just_next  = just_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.store = 1'b1;
                    if (word_end || text_end)
                    begin
                        te_next    = text_end;
                        state_next = S_DECIDE;
                    end
                end
            end
            S_DECIDE:
            begin
                if (stat.flush)
                begin
                    just_next  = 1'b1;
                    state_next = S_SETUP;
                end
                else
                begin
                    cmd.append = 1'b1;
                    if (te_reg)
                    begin
                        just_next  = 1'b0;
                        state_next = S_SETUP;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_WORD;
            end
            S_WORD:
            begin
                cmd.load_word = 1'b1;
                state_next    = S_LET;
            end
            S_LET:
            begin
                if (stat.prod_ok)
                begin
                    cmd.letter = 1'b1;
                    if (!stat.last_letter)
                        state_next = S_RD;
                    else if (stat.more_words)
                        state_next = S_GPREP;
                    else
                        state_next = S_PAD;
                end
            end
            S_RD:
            begin
                state_next = S_LET;
            end
            S_GPREP:
            begin
                if (just_reg && stat.gaps_nz)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    cmd.gap_load = 1'b1;
                    state_next   = S_GAP;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.gap_load = 1'b1;
                    state_next   = S_GAP;
                end
            end
            S_GAP:
            begin
                if (stat.prod_ok)
                begin
                    cmd.gap = 1'b1;
                    if (stat.gap_last)
                    begin
                        cmd.next_word = 1'b1;
                        state_next    = S_WORD;
                    end
                end
            end
            S_PAD:
            begin
                if (stat.line_full)
                    state_next = S_END;
                else if (stat.prod_ok)
                    cmd.pad = 1'b1;
            end
            S_END:
            begin
                cmd.clear_line = 1'b1;
                if (just_reg)
                    state_next = S_APPEND;
                else
                begin
                    cmd.clr_ovf = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_APPEND:
            begin
                cmd.append = 1'b1;
                if (te_reg)
                begin
                    just_next  = 1'b0;
                    state_next = S_SETUP;
                end
                else
                begin
                    cmd.clr_ovf = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        cmd.justify    = just_reg;
        cmd.final_line = !just_reg || !te_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            te_reg    <= 1'b0;
            just_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            te_reg    <= te_next;
            just_reg  <= just_next;
        end
    end

endmodule

@@ tb/sv/tb_pkg.sv @@
`timescale 1ns / 1ps
// Shared types for the full-justify testbench: one character transfer and one output beat.
// Depends on tfj_pkg.
package tb_pkg;
    import tfj_pkg::*;

    typedef struct packed {
        logic [7:0] character;
        logic       word_end;
        logic       text_end;
    } char_item_t;

    typedef struct packed {
        logic [63:0] packed_chars;
        logic [3:0]  char_count;
        logic        line_end;
        logic        word_too_long;
        logic        run_last;
    } beat_t;
endpackage

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for text_full_justify: random and directed word streams, a line
// justification predictor and a beat checker. Depends on tfj_pkg, tfj_if, tb_pkg.
module testbench;
    import tfj_pkg::*;
    import tb_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tfj_in_if  chars();
    tfj_out_if lines();
    tfj_cfg_if cfg();

    text_full_justify dut (.clk(clk), .rst_n(rst_n), .chars(chars), .lines(lines), .cfg(cfg));

    always #1 clk = ~clk;

    char_item_t pending_chars[$];
    beat_t      expected_beats[$];
    int         src_idle_pct = 0;
    int         snk_stall_pct = 0;
    bit         failed = 1'b0;
    int         idle_cycles = 0;

    // predictor state
    logic [7:0] held_line[MAX_WIDTH];
    logic [7:0] held_word[MAX_WIDTH];
    int         held_lens[MAX_WORDS + 1];
    int         width_reg = 64;
    int         word_cnt = 0;
    int         letter_cnt = 0;
    int         word_len = 0;
    bit         overflow = 1'b0;

    function automatic int cur_width();
        int w;
        w = width_reg;
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    task automatic push_line(input bit justify, input int w);
        logic [7:0] buf_line[MAX_WIDTH];
        int pos, src, gaps, blanks, s, words;
        beat_t b;
        pos = 0;
        src = 0;
        words = word_cnt > MAX_WORDS + 1 ? MAX_WORDS + 1 : word_cnt;
        gaps = words ? words - 1 : 0;
        blanks = w > letter_cnt ? w - letter_cnt : 0;
        foreach (buf_line[i]) buf_line[i] = BLANK;
        for (int k = 0; k < words; k++)
        begin
            for (int i = 0; i < held_lens[k]; i++)
            begin
                if (pos < w && src < MAX_WIDTH) buf_line[pos] = held_line[src];
                pos++;
                src++;
            end
            if (k + 1 < words)
            begin
                s = 1;
                if (justify && gaps > 0)
                begin
                    s = (blanks + gaps - 1) / gaps;
                    blanks = blanks >= s ? blanks - s : 0;
                    gaps--;
                end
                pos += s;
            end
        end
        for (int off = 0; off < w; off += BYTES_PER_RESULT)
        begin
            int cnt;
            cnt = w - off > BYTES_PER_RESULT ? BYTES_PER_RESULT : w - off;
            b = '0;
            for (int i = 0; i < cnt; i++) b.packed_chars[8*i +: 8] = buf_line[off + i];
            b.char_count = 4'(cnt);
            b.line_end = (off + cnt == w);
            b.word_too_long = overflow;
            expected_beats.insert(expected_beats.size(), b);
        end
    endtask

    task automatic predict_justify(input char_item_t it);
        int w, n0;
        w = cur_width();
        n0 = expected_beats.size();
        if (word_len < w)
        begin
            held_word[word_len] = it.character;
            word_len++;
        end
        else
            overflow = 1'b1;
        if (it.word_end || it.text_end)
        begin
            if (word_cnt > 0 && letter_cnt + word_cnt + word_len > w)
            begin
                push_line(1'b1, w);
                word_cnt = 0;
                letter_cnt = 0;
            end
            if (word_cnt < MAX_WORDS + 1 && letter_cnt + word_len <= MAX_WIDTH)
            begin
                for (int i = 0; i < word_len; i++) held_line[letter_cnt + i] = held_word[i];
                held_lens[word_cnt] = word_len;
                letter_cnt += word_len;
                word_cnt++;
            end
            word_len = 0;
            if (it.text_end)
            begin
                push_line(1'b0, w);
                word_cnt = 0;
                letter_cnt = 0;
            end
        end
        if (expected_beats.size() > n0)
        begin
            expected_beats[$].run_last = 1'b1;
            overflow = 1'b0;
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars.valid <= 1'b0;
            chars.character <= '0;
            chars.word_end <= 1'b0;
            chars.text_end <= 1'b0;
        end
        else if (!chars.valid || chars.ready)
        begin
            if (chars.valid) void'(pending_chars.pop_front());
            if (pending_chars.size() > 0 && $urandom_range(99) >= src_idle_pct)
            begin
                chars.valid <= 1'b1;
                chars.character <= pending_chars[0].character;
                chars.word_end <= pending_chars[0].word_end;
                chars.text_end <= pending_chars[0].text_end;
            end
            else
                chars.valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lines.ready <= 1'b0;
        else
            lines.ready <= $urandom_range(99) >= snk_stall_pct;
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (chars.valid && chars.ready)
                predict_justify('{chars.character, chars.word_end, chars.text_end});
            if (lines.valid && lines.ready)
            begin
                beat_t got, exp_b;
                got = '{lines.packed_chars, lines.char_count, lines.line_end,
                        lines.word_too_long, lines.run_last};
                if (expected_beats.size() == 0)
                begin
                    $display("%0t unexpected beat: expected none, actual %h", $time, got);
                    failed = 1'b1;
                end
                else
                begin
                    exp_b = expected_beats.pop_front();
                    if (got.packed_chars !== exp_b.packed_chars)
                        $display("%0t packed_chars: expected %h, actual %h", $time,
                                 exp_b.packed_chars, got.packed_chars);
                    if (got.char_count !== exp_b.char_count)
                        $display("%0t char_count: expected %0d, actual %0d", $time,
                                 exp_b.char_count, got.char_count);
                    if (got.line_end !== exp_b.line_end)
                        $display("%0t line_end: expected %b, actual %b", $time,
                                 exp_b.line_end, got.line_end);
                    if (got.word_too_long !== exp_b.word_too_long)
                        $display("%0t word_too_long: expected %b, actual %b", $time,
                                 exp_b.word_too_long, got.word_too_long);
                    if (got.run_last !== exp_b.run_last)
                        $display("%0t run_last: expected %b, actual %b", $time,
                                 exp_b.run_last, got.run_last);
                    if (got !== exp_b) failed = 1'b1;
                end
            end
            if ((chars.valid && chars.ready) || (lines.valid && lines.ready) ||
                (cfg.valid && cfg.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic write_width(input int value);
        cfg.line_width <= value[6:0];
        cfg.valid <= 1'b1;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 1'b0;
        width_reg = value & 'h7f;
        word_cnt = 0;
        letter_cnt = 0;
        word_len = 0;
        overflow = 1'b0;
    endtask

    task automatic add_char(input logic [7:0] c, input bit we, input bit te);
        char_item_t it;
        it.character = c;
        it.word_end = we;
        it.text_end = te;
        pending_chars.insert(pending_chars.size(), it);
    endtask

    task automatic add_word(input int len, input bit last, input bit blanks_ok);
        logic [7:0] c;
        bit we, te;
        for (int i = 0; i < len; i++)
        begin
            c = blanks_ok ? 8'($urandom_range(255)) : 8'($urandom_range(33, 126));
            we = (i == len - 1);
            te = last && (i == len - 1);
            if (i == len - 1 && last && $urandom_range(3) == 0) we = 1'b0;
            add_char(c, we, te);
        end
    endtask

    task automatic drain();
        while (pending_chars.size() > 0 || chars.valid || expected_beats.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic random_text(input int items);
        int n, w;
        n = 0;
        w = cur_width();
        while (n < items)
        begin
            int len, r;
            r = $urandom_range(99);
            if (r < 5) len = w + $urandom_range(1, 4);
            else if (r < 20) len = $urandom_range(1, w);
            else len = $urandom_range(1, w < 6 ? w : 6);
            add_word(len, $urandom_range(7) == 0 || n + len >= items, $urandom_range(9) == 0);
            n += len;
        end
    endtask

    initial
    begin
        cfg.valid = 1'b0;
        cfg.line_width = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: full-range bytes, lone word, text end without word end, overflow
        add_char(8'h00, 1'b1, 1'b0);
        add_char(8'hff, 1'b1, 1'b0);
        add_char(8'h20, 1'b0, 1'b1);
        drain();
        write_width(5);
        add_word(8, 1'b0, 1'b0);
        add_word(2, 1'b0, 1'b0);
        add_word(1, 1'b0, 1'b0);
        add_word(3, 1'b1, 1'b0);
        drain();
        write_width(0);
        add_word(3, 1'b1, 1'b0);
        drain();
        write_width(127);
        add_word(1, 1'b0, 1'b0);
        add_word(1, 1'b1, 1'b0);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct = 0;
                    snk_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct = 71;
                    snk_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct = 0;
                    snk_stall_pct = 71;
                end
                default:
                begin
                    src_idle_pct = 11;
                    snk_stall_pct = 11;
                end
            endcase
            write_width(phase == 0 ? 1 : phase == 1 ? 64 : $urandom_range(2, 20));
            random_text(60);
            drain();
        end

        if (!failed)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/tfj_pkg.sv
rtl/tfj_if.sv
rtl/tfj_div.sv
rtl/tfj_datapath.sv
rtl/tfj_ctrl.sv
rtl/text_full_justify.sv
tb/sv/tb_pkg.sv
tb/sv/testbench.sv
